/* design/e2f_pkg.sv */
// package for the element to float32 converter: kind codes and widths
`timescale 1ns / 1ps
`default_nettype none
package e2f_pkg;

    typedef enum logic [3:0] {
        KIND_F32  = 4'd0,
        KIND_I32  = 4'd1,
        KIND_I64  = 4'd2,
        KIND_I16  = 4'd3,
        KIND_U16  = 4'd4,
        KIND_I8   = 4'd5,
        KIND_U8   = 4'd6,
        KIND_BOOL = 4'd7,
        KIND_F16  = 4'd8
    } elem_kind_t;

    localparam int RAW_W   = 64;
    localparam int FLOAT_W = 32;
    localparam int POS_W   = 6;
    localparam logic [31:0] FLOAT_ONE = 32'h3f80_0000;

    // apb register addresses
    localparam logic [1:0] ADDR_ELEMENT_KIND = 2'd0;

endpackage
`default_nettype wire

/* design/element_to_float32_converter.sv */
// element to float32 converter: four stage pipeline with apb kind register
//
// usage:
//   write element_kind over the apb port (byte address 0) while the stream is
//   idle. then stream raw elements on s_axis: s_axis_tdata holds raw_value
//   (64 bits, right aligned), s_axis_tlast marks the last element of a tensor.
//   each beat gives exactly one result beat on m_axis: m_axis_tdata holds the
//   ieee single bit pattern, m_axis_tlast copies the input tlast.
// throughput: one beat per cycle; every stage is a register with a valid bit
//   and the whole pipe advances whenever the output register is empty or is
//   being taken, so s_axis_tready only falls when the output beat is stalled.
// stages:
//   1 sign/magnitude extraction and the simple kinds (f32, bool, f16)
//   2 leading one position over the 64 bit magnitude
//   3 normalize shift and round bits
//   4 round to nearest even, pack exponent, output register
// reset: aresetn (synchronous, active low) clears all valid bits and sets
//   element_kind back to f32.
// stall: when m_axis_tready is low with a beat waiting, the pipe holds and
//   nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module element_to_float32_converter
    import e2f_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // apb
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [1:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // input stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,   // [63:0] raw_value
    input  wire logic         s_axis_tlast,   // last_element
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // [31:0] float_bits
    output logic              m_axis_tlast    // last_out
);

    logic [3:0] kind_reg;
    logic       adv;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ELEMENT_KIND) ? {28'd0, kind_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_F32;
        end else if (psel && penable && pwrite && paddr == ADDR_ELEMENT_KIND) begin
            kind_reg <= pwdata[3:0];
        end
    end

    // whole pipe moves together unless the output beat is stuck
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // ---------------- stage 1: sign, magnitude, direct results
    logic              v1_reg, v1_next;
    logic              l1_reg;
    logic              int1_reg, int1_next;   // needs integer conversion
    logic              s1_reg, s1_next;
    logic [RAW_W-1:0]  m1_reg, m1_next;
    logic [31:0]       d1_reg, d1_next;       // direct result
    logic [63:0]       x;
    logic [4:0]        he;
    logic [9:0]        hf;
    logic [3:0]        hlz;
    logic [10:0]       hn;

    assign x = s_axis_tdata;
    assign v1_next = s_axis_tvalid;

    always_comb begin
        he = x[14:10];
        hf = x[9:0];
        hlz = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (hf[i]) hlz = 4'(9 - i);
        end
        hn = {1'b0, hf} << (hlz + 4'd1);
        int1_next = 1'b1;
        s1_next = 1'b0;
        m1_next = {56'd0, x[7:0]};
        d1_next = 32'd0;
        unique case (kind_reg)
            KIND_F32: begin
                int1_next = 1'b0;
                d1_next = x[31:0];
            end
            KIND_I32: begin
                s1_next = x[31];
                m1_next = {32'd0, x[31] ? (~x[31:0] + 32'd1) : x[31:0]};
            end
            KIND_I64: begin
                s1_next = x[63];
                m1_next = x[63] ? (~x + 64'd1) : x;
            end
            KIND_I16: begin
                s1_next = x[15];
                m1_next = {48'd0, x[15] ? (~x[15:0] + 16'd1) : x[15:0]};
            end
            KIND_U16: m1_next = {48'd0, x[15:0]};
            KIND_I8: begin
                s1_next = x[7];
                m1_next = {56'd0, x[7] ? (~x[7:0] + 8'd1) : x[7:0]};
            end
            KIND_BOOL: begin
                int1_next = 1'b0;
                d1_next = (x[7:0] != 8'd0) ? FLOAT_ONE : 32'd0;
            end
            KIND_F16: begin
                int1_next = 1'b0;
                if (he == 5'd0 && hf == 10'd0)
                    d1_next = {x[15], 31'd0};
                else if (he == 5'd0)
                    d1_next = {x[15], 8'(8'd112 - {4'd0, hlz}), hn[9:0], 13'd0};
                else if (he == 5'h1f)
                    d1_next = {x[15], 8'hff, hf, 13'd0};
                else
                    d1_next = {x[15], 8'({3'd0, he} + 8'd112), hf, 13'd0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= v1_next;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            l1_reg <= s_axis_tlast; int1_reg <= int1_next; s1_reg <= s1_next;
            m1_reg <= m1_next; d1_reg <= d1_next;
        end
    end

    // ---------------- stage 2: leading one position
    logic              v2_reg, l2_reg, int2_reg, s2_reg, z2_reg;
    logic [RAW_W-1:0]  m2_reg;
    logic [31:0]       d2_reg;
    logic [POS_W-1:0]  p2_reg, p2_next;

    always_comb begin
        p2_next = '0;
        for (int i = 0; i < RAW_W; i++) begin
            if (m1_reg[i]) p2_next = POS_W'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            l2_reg <= l1_reg; int2_reg <= int1_reg; s2_reg <= s1_reg;
            z2_reg <= (m1_reg == '0); m2_reg <= m1_reg; d2_reg <= d1_reg;
            p2_reg <= p2_next;
        end
    end

    // ---------------- stage 3: normalize so the leading one sits at bit 63
    logic              v3_reg, l3_reg, int3_reg, s3_reg, z3_reg;
    logic [31:0]       d3_reg;
    logic [POS_W-1:0]  p3_reg;
    logic [23:0]       mant3_reg;
    logic              g3_reg, st3_reg;
    logic [RAW_W-1:0]  nrm;

    assign nrm = m2_reg << (POS_W'(RAW_W - 1) - p2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            l3_reg <= l2_reg; int3_reg <= int2_reg; s3_reg <= s2_reg;
            z3_reg <= z2_reg; d3_reg <= d2_reg; p3_reg <= p2_reg;
            mant3_reg <= nrm[63:40];
            g3_reg <= nrm[39];
            st3_reg <= (nrm[38:0] != '0);
        end
    end

    // ---------------- stage 4: round to nearest even and pack
    logic        v4_reg, l4_reg;
    logic [31:0] f4_reg, f4_next;
    logic [24:0] rnd;
    logic [7:0]  ex;

    always_comb begin
        rnd = {1'b0, mant3_reg} + 25'(g3_reg && (st3_reg || mant3_reg[0]));
        ex = 8'd127 + {2'd0, p3_reg} + {7'd0, rnd[24]};
        if (!int3_reg)     f4_next = d3_reg;
        else if (z3_reg)   f4_next = 32'd0;
        else if (rnd[24])  f4_next = {s3_reg, ex, 23'd0};
        else               f4_next = {s3_reg, ex, rnd[22:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (adv) v4_reg <= v3_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            l4_reg <= l3_reg;
            f4_reg <= f4_next;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = f4_reg;
    assign m_axis_tlast  = l4_reg;

    // an accepted beat shows up at stage 1 next cycle
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> v1_reg)
        else $error("accepted beat lost at stage 1");

    // a stalled output freezes the last stage
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(f4_reg))
        else $error("stalled result changed");

    // zero magnitude means no leading one
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && z2_reg |-> p2_reg == '0)
        else $error("leading one found in zero");

endmodule
`default_nettype wire
